// ===== design/nfc_fe_pkg.sv =====
// ----------------------------------------------------------------------------
// NFC host frame encoder package
// Byte constants, register reset value and emit step codes.
// ----------------------------------------------------------------------------
package nfc_fe_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned StepWidth  = 4;

   typedef logic [ByteWidth-1:0] byte_type;
   typedef logic [StepWidth-1:0] step_type;

   localparam byte_type PREAMBLE_BYTE  = 8'h00;
   localparam byte_type START_CODE_HI  = 8'hFF;
   localparam byte_type POSTAMBLE_BYTE = 8'h00;
   localparam byte_type IDENT_RESET    = 8'hD4;

   // emit steps of one transaction, header first
   localparam step_type STEP_PRE0  = 4'd0;
   localparam step_type STEP_PRE1  = 4'd1;
   localparam step_type STEP_START = 4'd2;
   localparam step_type STEP_LEN   = 4'd3;
   localparam step_type STEP_LCS   = 4'd4;
   localparam step_type STEP_IDENT = 4'd5;
   localparam step_type STEP_DATA  = 4'd6;
   localparam step_type STEP_DCS   = 4'd7;
   localparam step_type STEP_POST  = 4'd8;

   typedef struct packed {
      logic     hdr;
      logic     trl;
      byte_type data;
      byte_type lenf;
      byte_type ident;
      byte_type dcs;
   } rec_type;

endpackage

// ===== design/nfc_host_frame_encoder_core.sv =====
// ----------------------------------------------------------------------------
// NFC host frame encoder core
// Wraps command payload bytes into information frames: preamble, start code,
// LEN, LCS, identifier, payload, DCS and postamble.
// ----------------------------------------------------------------------------
// Path: the bytes of a transaction pass through the record register and then
//   the output register; one byte leaves per cycle unless rsp_tready stalls it.
//   A mid-frame transaction yields 1 byte, a frame-closing one 3 bytes and a
//   frame-opening one 7 to 9 bytes.
// Reset: synchronous; clears frame state, empties both stages and loads the
//   identifier register with 0xD4.
module nfc_host_frame_encoder_core (
   input  logic        clock,
   input  logic        reset,
   // csr
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data,     // frame_identifier
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,    // [7:0] payload_byte, [15:8] payload_length
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,    // [7:0] frame_byte
   output logic        rsp_tlast,    // last_of_run
   output logic        rsp_tuser     // [0] end_of_frame
);

   nfc_fe_pkg::byte_type ident_ff;
   logic                 inside_ff,  inside_in;
   nfc_fe_pkg::byte_type remain_ff,  remain_in;
   nfc_fe_pkg::byte_type sum_ff,     sum_in;

   logic                 r_valid_ff, r_valid_in;
   nfc_fe_pkg::rec_type  rec_ff,     rec_in;
   nfc_fe_pkg::step_type step_ff,    step_in;

   logic                 o_valid_ff, o_valid_in;
   nfc_fe_pkg::byte_type o_byte_ff,  o_byte_in;
   logic                 o_eof_ff,   o_eof_in;
   logic                 o_last_ff,  o_last_in;

   nfc_fe_pkg::byte_type pay_byte, pay_len, len_eff, base_sum, base_rem, sum_new, rem_new;
   logic                 req_fire, o_load, r_move, r_last;

   assign pay_byte = req_tdata[7:0];
   assign pay_len  = req_tdata[15:8];
   assign csr_ready = 1'b1;

   assign o_load = !o_valid_ff || rsp_tready;
   assign r_move = r_valid_ff && o_load;
   assign r_last = rec_ff.trl ? (step_ff == nfc_fe_pkg::STEP_POST)
                              : (step_ff == nfc_fe_pkg::STEP_DATA);
   assign req_tready = !r_valid_ff || (r_move && r_last);
   assign req_fire   = req_tvalid && req_tready;

   // frame bookkeeping at acceptance
   always_comb begin
      len_eff  = (pay_len == 8'd0) ? 8'd1 : pay_len;
      base_sum = inside_ff ? sum_ff : ident_ff;
      base_rem = inside_ff ? remain_ff : len_eff;
      sum_new  = base_sum + pay_byte;
      rem_new  = base_rem - 8'd1;

      rec_in.hdr   = !inside_ff;
      rec_in.trl   = (rem_new == 8'd0);
      rec_in.data  = pay_byte;
      rec_in.lenf  = len_eff + 8'd1;
      rec_in.ident = ident_ff;
      rec_in.dcs   = 8'd0 - sum_new;

      inside_in = inside_ff;
      remain_in = remain_ff;
      sum_in    = sum_ff;
      if (req_fire) begin
         inside_in = !rec_in.trl;
         remain_in = rem_new;
         sum_in    = rec_in.trl ? 8'd0 : sum_new;
      end
   end

   // record stage: advance step, take next transaction on the last one
   always_comb begin
      r_valid_in = r_valid_ff;
      step_in    = step_ff;
      if (r_move) begin
         if (r_last) begin
            r_valid_in = 1'b0;
         end else begin
            step_in = step_ff + 4'd1;
         end
      end
      if (req_fire) begin
         r_valid_in = 1'b1;
         step_in    = rec_in.hdr ? nfc_fe_pkg::STEP_PRE0 : nfc_fe_pkg::STEP_DATA;
      end
   end

   // output stage
   always_comb begin
      o_valid_in = o_valid_ff;
      o_byte_in  = o_byte_ff;
      o_eof_in   = o_eof_ff;
      o_last_in  = o_last_ff;
      if (o_load) begin
         o_valid_in = r_valid_ff;
         o_eof_in   = (step_ff == nfc_fe_pkg::STEP_POST);
         o_last_in  = r_last;
         unique case (step_ff)
            nfc_fe_pkg::STEP_PRE0:  o_byte_in = nfc_fe_pkg::PREAMBLE_BYTE;
            nfc_fe_pkg::STEP_PRE1:  o_byte_in = nfc_fe_pkg::PREAMBLE_BYTE;
            nfc_fe_pkg::STEP_START: o_byte_in = nfc_fe_pkg::START_CODE_HI;
            nfc_fe_pkg::STEP_LEN:   o_byte_in = rec_ff.lenf;
            nfc_fe_pkg::STEP_LCS:   o_byte_in = 8'd0 - rec_ff.lenf;
            nfc_fe_pkg::STEP_IDENT: o_byte_in = rec_ff.ident;
            nfc_fe_pkg::STEP_DATA:  o_byte_in = rec_ff.data;
            nfc_fe_pkg::STEP_DCS:   o_byte_in = rec_ff.dcs;
            nfc_fe_pkg::STEP_POST:  o_byte_in = nfc_fe_pkg::POSTAMBLE_BYTE;
            default:                o_byte_in = nfc_fe_pkg::POSTAMBLE_BYTE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ident_ff   <= nfc_fe_pkg::IDENT_RESET;
         inside_ff  <= 1'b0;
         remain_ff  <= 8'd0;
         sum_ff     <= 8'd0;
         r_valid_ff <= 1'b0;
         step_ff    <= nfc_fe_pkg::STEP_PRE0;
         o_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            ident_ff <= csr_data;
         end
         inside_ff  <= inside_in;
         remain_ff  <= remain_in;
         sum_ff     <= sum_in;
         r_valid_ff <= r_valid_in;
         step_ff    <= step_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rec_ff <= rec_in;
      end
      o_byte_ff <= o_byte_in;
      o_eof_ff  <= o_eof_in;
      o_last_ff <= o_last_in;
   end

   assign rsp_tvalid = o_valid_ff;
   assign rsp_tdata  = o_byte_ff;
   assign rsp_tlast  = o_last_ff;
   assign rsp_tuser  = o_eof_ff;

   a_eof_closes_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("postamble not last of run");

   a_open_frame_counts: assert property (@(posedge clock) disable iff (reset)
      inside_ff |-> remain_ff != 8'd0)
      else $error("open frame with no bytes remaining");

   a_closed_sum_clear: assert property (@(posedge clock) disable iff (reset)
      !inside_ff |-> sum_ff == 8'd0)
      else $error("running sum not cleared outside frame");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      r_valid_ff |-> step_ff <= nfc_fe_pkg::STEP_POST)
      else $error("emit step out of range");

   a_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      r_valid_ff && !o_load |=> $stable(step_ff) && r_valid_ff)
      else $error("record advanced while output stalled");

endmodule

// ===== dv/nfc_host_frame_encoder_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NFC host frame encoder checker
// Watches the csr, request and response channels of the frame encoder,
// builds the framed byte stream that each accepted payload byte must cause
// and compares every accepted response byte with the oldest one due.
// ----------------------------------------------------------------------------
module nfc_host_frame_encoder_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [7:0]  csr_data,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        rsp_tuser,
   output int          bytes_due,
   output int          fail_count
);

   typedef struct packed {
      nfc_fe_pkg::byte_type frame_byte;
      logic                 end_of_frame;
      logic                 last_of_run;
   } framed_byte_type;

   framed_byte_type framed_bytes_due[$];

   nfc_fe_pkg::byte_type identifier;
   logic                 frame_open;
   nfc_fe_pkg::byte_type payload_left;
   nfc_fe_pkg::byte_type frame_sum;

   task automatic push_byte(input nfc_fe_pkg::byte_type value, input logic eof);
      framed_byte_type fb;
      fb.frame_byte   = value;
      fb.end_of_frame = eof;
      fb.last_of_run  = 1'b0;
      framed_bytes_due.push_back(fb);
   endtask

   // work out the framed bytes caused by one payload byte
   task automatic encode_payload_byte(input nfc_fe_pkg::byte_type payload,
                                      input nfc_fe_pkg::byte_type length);
      nfc_fe_pkg::byte_type len_field;
      nfc_fe_pkg::byte_type count;
      count = (length == 8'd0) ? 8'd1 : length;
      if (!frame_open) begin
         len_field = count + 8'd1;
         push_byte(nfc_fe_pkg::PREAMBLE_BYTE, 1'b0);
         push_byte(nfc_fe_pkg::PREAMBLE_BYTE, 1'b0);
         push_byte(nfc_fe_pkg::START_CODE_HI, 1'b0);
         push_byte(len_field, 1'b0);
         push_byte(8'd0 - len_field, 1'b0);
         push_byte(identifier, 1'b0);
         frame_sum    = identifier;
         payload_left = count;
         frame_open   = 1'b1;
      end
      push_byte(payload, 1'b0);
      frame_sum    = frame_sum + payload;
      payload_left = payload_left - 8'd1;
      if (payload_left == 8'd0) begin
         push_byte(8'd0 - frame_sum, 1'b0);
         push_byte(nfc_fe_pkg::POSTAMBLE_BYTE, 1'b1);
         frame_open = 1'b0;
         frame_sum  = 8'd0;
      end
      framed_bytes_due[$].last_of_run = 1'b1;
   endtask

   always @(posedge clock) begin
      framed_byte_type seen;
      framed_byte_type due;
      if (reset) begin
         identifier   = nfc_fe_pkg::IDENT_RESET;
         frame_open   = 1'b0;
         payload_left = 8'd0;
         frame_sum    = 8'd0;
         fail_count   = 0;
         framed_bytes_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            identifier = csr_data;
         end
         if (req_tvalid && req_tready) begin
            encode_payload_byte(req_tdata[7:0], req_tdata[15:8]);
         end
         if (rsp_tvalid && rsp_tready) begin
            seen = '{rsp_tdata, rsp_tuser, rsp_tlast};
            if (framed_bytes_due.size() == 0) begin
               fail_count = fail_count + 1;
               if (fail_count <= 10) begin
                  $display("%0t: unexpected frame byte %h eof %b tlast %b",
                           $time, seen.frame_byte, seen.end_of_frame, seen.last_of_run);
               end
            end else begin
               due = framed_bytes_due.pop_front();
               if (seen !== due) begin
                  fail_count = fail_count + 1;
                  if (fail_count <= 10) begin
                     $display("%0t: frame byte expected %h eof %b tlast %b, got %h eof %b tlast %b",
                              $time, due.frame_byte, due.end_of_frame, due.last_of_run,
                              seen.frame_byte, seen.end_of_frame, seen.last_of_run);
                  end
               end
            end
         end
      end
      bytes_due <= framed_bytes_due.size();
   end

endmodule

// ===== dv/nfc_host_frame_encoder_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NFC host frame encoder testbench
// Drives payload bytes and identifier writes with random idling on both
// streams, directed frames first and random frames after, and reports the
// verdict from the checker's failure count and the bytes still due.
// ----------------------------------------------------------------------------
module nfc_host_frame_encoder_core_test;

   localparam int CycleLimit = 400000;
   localparam int RandomItems = 220;

   logic        clock;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;

   int          bytes_due;
   int          fail_count;
   int          cycle_count;
   logic        gaps_on;

   nfc_host_frame_encoder_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   nfc_host_frame_encoder_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .bytes_due  (bytes_due),
      .fail_count (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // stall the response stream at random
   always @(negedge clock) begin
      rsp_tready <= gaps_on ? ($urandom_range(99) >= 26) : 1'b1;
   end

   task automatic send_payload_byte(input nfc_fe_pkg::byte_type payload,
                                    input nfc_fe_pkg::byte_type length);
      while (gaps_on && $urandom_range(99) < 26) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {length, payload};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // hold until every framed byte has left
   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (bytes_due != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_identifier(input nfc_fe_pkg::byte_type value);
      wait_drained();
      csr_valid = 1'b1;
      csr_data  = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic send_frame(input nfc_fe_pkg::byte_type length, input bit extreme_bytes);
      int count;
      nfc_fe_pkg::byte_type payload;
      count = (length == 8'd0) ? 1 : int'(length);
      for (int i = 0; i < count; i++) begin
         if (extreme_bytes && $urandom_range(3) == 0) payload = $urandom_range(1) ? 8'hFF : 8'h00;
         else payload = nfc_fe_pkg::byte_type'($urandom_range(255));
         send_payload_byte(payload,
                           (i == 0) ? length : nfc_fe_pkg::byte_type'($urandom_range(255)));
      end
   endtask

   initial begin
      int sent;
      int frames_left;
      int pick;
      nfc_fe_pkg::byte_type length;

      reset       = 1'b1;
      csr_valid   = 1'b0;
      csr_data    = 8'd0;
      req_tvalid  = 1'b0;
      req_tdata   = 16'd0;
      rsp_tready  = 1'b0;
      gaps_on     = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset identifier, zero length, single byte, byte extremes
      send_payload_byte(8'h00, 8'h00);
      send_payload_byte(8'hFF, 8'h01);
      send_payload_byte(8'hFF, 8'h03);
      send_payload_byte(8'h00, 8'hFF);
      send_payload_byte(8'hA5, 8'h00);
      write_identifier(8'h00);
      send_payload_byte(8'hFF, 8'h02);
      send_payload_byte(8'hFF, 8'h5A);
      write_identifier(8'hFF);
      send_payload_byte(8'h01, 8'h01);
      send_payload_byte(8'h80, 8'h01);
      write_identifier(8'hFF);
      // identifier change inside an open frame
      send_payload_byte(8'h7F, 8'h04);
      send_payload_byte(8'h01, 8'hAA);
      write_identifier(8'h12);
      send_payload_byte(8'hC3, 8'h55);
      send_payload_byte(8'h3C, 8'h00);
      write_identifier(nfc_fe_pkg::IDENT_RESET);

      // random frames, new identifier every few frames
      sent = 0;
      frames_left = 0;
      while (sent < RandomItems) begin
         gaps_on = !(sent >= 70 && sent < 130);
         if (frames_left == 0) begin
            case ($urandom_range(5))
               0:       write_identifier(8'h00);
               1:       write_identifier(8'hFF);
               2:       write_identifier(nfc_fe_pkg::IDENT_RESET);
               default: write_identifier(nfc_fe_pkg::byte_type'($urandom_range(255)));
            endcase
            frames_left = $urandom_range(6, 1);
         end
         pick = $urandom_range(99);
         if (pick < 6) length = 8'd0;
         else if (pick < 60) length = nfc_fe_pkg::byte_type'($urandom_range(6, 1));
         else if (pick < 90) length = nfc_fe_pkg::byte_type'($urandom_range(30, 7));
         else length = nfc_fe_pkg::byte_type'($urandom_range(60, 31));
         send_frame(length, 1'b1);
         sent = sent + ((length == 8'd0) ? 1 : int'(length));
         frames_left = frames_left - 1;
      end

      // open a frame of the largest length last: LEN and LCS wrap to 00
      send_payload_byte(nfc_fe_pkg::byte_type'($urandom_range(255)), 8'hFF);
      req_tvalid = 1'b0;

      while (bytes_due != 0) @(negedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && bytes_due == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
